// ----- sv/gps_pkg.sv -----
package gps_pkg;

  // default width of the uniform source words
  localparam int UNIFORM_BITS_DEF = 32;

  // field widths
  localparam int UW      = 32;  // uniform word on the bus
  localparam int SIGMA_W = 24;
  localparam int MEAN_W  = 32;
  localparam int OUT_W   = 32;

  // -log2 unit
  localparam int LOG_ITER = 24;          // fraction bits, one squaring each
  localparam int LOG_LAT  = LOG_ITER + 3; // lzc, normalise, squarings, final
  localparam int L_W      = 30;          // Q.24 result, at most 62.0

  // pipelined square roots
  localparam int SQS_IW = 64;            // radicand of sqrt(R)
  localparam int SQG_IW = 56;            // radicand of sqrt(T << 24)

  // divider: quotient Q.30, never above 1.0
  localparam int QW = 31;

  localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [29:0] L_MAX       = 30'd1040187392;  // 62.0 in Q.24
  localparam logic [30:0] Q_ONE       = 31'h4000_0000;   // 1.0 in Q.30

  // register indexes
  localparam logic [1:0] REG_SIGMA  = 2'd0;
  localparam logic [1:0] REG_X_MEAN = 2'd1;
  localparam logic [1:0] REG_Y_MEAN = 2'd2;

  localparam logic [23:0] SIGMA_RST = 24'd65536;

endpackage

// ----- sv/gps_delay.sv -----
module gps_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= din;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign dout = sh_r[N-1];

endmodule

// ----- sv/gps_log2.sv -----
// -log2(r / 2^62) in Q.24: leading one, normalise, then one squaring per stage
module gps_log2 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] r,
  output logic [gps_pkg::L_W-1:0] l
);

  localparam int NI = gps_pkg::LOG_ITER;

  logic [63:0] r0_r;
  logic [5:0]  p0_r;
  logic [5:0]  p_lzc;

  always_comb begin
    p_lzc = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (r[i]) p_lzc = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r <= r;
      p0_r <= p_lzc;
    end
  end

  // Q1.31 mantissa with its leading one at bit 31
  logic [31:0] m1_r;
  logic [5:0]  p1_r;
  logic [63:0] norm;

  assign norm = r0_r << (6'd63 - p0_r);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r <= norm[63:32];
      p1_r <= p0_r;
    end
  end

  logic [31:0] m_r [NI];
  logic [NI-1:0] f_r [NI];
  logic [5:0]  p_r [NI];

  for (genvar j = 0; j < NI; j++) begin : g_sq
    logic [31:0]   m_in;
    logic [NI-1:0] f_in;
    logic [5:0]    p_in;
    logic [63:0]   sq;
    logic [32:0]   t;

    if (j == 0) begin : g_first
      assign m_in = m1_r;
      assign f_in = '0;
      assign p_in = p1_r;
    end else begin : g_next
      assign m_in = m_r[j-1];
      assign f_in = f_r[j-1];
      assign p_in = p_r[j-1];
    end

    assign sq = m_in * m_in;
    assign t  = sq[63:31];

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[j] <= p_in;
        if (t[32]) begin
          m_r[j] <= t[32:1];
          f_r[j] <= {f_in[NI-2:0], 1'b1};
        end else begin
          m_r[j] <= t[31:0];
          f_r[j] <= {f_in[NI-2:0], 1'b0};
        end
      end
    end
  end

  logic [gps_pkg::L_W-1:0] l_r;
  logic [5:0]              ip;

  assign ip = 6'd62 - p_r[NI-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (p_r[NI-1] >= 6'd62) begin
        l_r <= '0;
      end else begin
        l_r <= {ip, 24'd0} - {6'd0, f_r[NI-1]};
      end
    end
  end

  assign l = l_r;

endmodule

// ----- sv/gps_isqrt.sv -----
// floor square root, restoring, one root bit per stage
module gps_isqrt #(
  parameter int IW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   rad,
  output logic [IW/2-1:0] root
);

  localparam int OW = IW / 2;
  localparam int RW = OW + 2;

  logic [IW-1:0] rad_r  [OW];
  logic [RW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];

  for (genvar i = 0; i < OW; i++) begin : g_st
    logic [IW-1:0] rad_in;
    logic [RW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic [RW+1:0] cand;
    logic [RW+1:0] trial;

    if (i == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign cand  = {rem_in, rad_in[IW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i] <= rad_in << 2;
        if (cand >= trial) begin
          rem_r[i]  <= RW'(cand - trial);
          root_r[i] <= {root_in[OW-2:0], 1'b1};
        end else begin
          rem_r[i]  <= cand[RW-1:0];
          root_r[i] <= {root_in[OW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_r[OW-1];

endmodule

// ----- sv/gps_div.sv -----
// trunc(mag * 2^30 / den), mag <= den, one quotient bit per stage
module gps_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            mag,
  input  logic [31:0]            den,
  output logic [gps_pkg::QW-1:0] quo
);

  localparam int QW = gps_pkg::QW;

  logic [31:0]   rem_r [QW];
  logic [31:0]   den_r [QW];
  logic [QW-1:0] q_r   [QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic [31:0]   rem_in;
    logic [31:0]   den_in;
    logic [QW-1:0] q_in;
    logic          bit_in;
    logic [32:0]   cand;

    if (i == 0) begin : g_first
      // upper dividend bits give quotient zero, leaving mag >> 1
      assign rem_in = {1'b0, mag[31:1]};
      assign den_in = den;
      assign q_in   = '0;
      assign bit_in = mag[0];
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign q_in   = q_r[i-1];
      assign bit_in = 1'b0;
    end

    assign cand = {rem_in, bit_in};

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[i] <= den_in;
        if (cand >= {1'b0, den_in}) begin
          rem_r[i] <= 32'(cand - {1'b0, den_in});
          q_r[i]   <= {q_in[QW-2:0], 1'b1};
        end else begin
          rem_r[i] <= cand[31:0];
          q_r[i]   <= {q_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[QW-1];

endmodule

// ----- sv/gaussian_polar_sampler.sv -----
// channel | dir | ports                        | fields (low bit up)
// in      | in  | in_tvalid/in_tready/in_tdata | uniform_a[31:0], uniform_b[63:32]
// out     | out  | out_tvalid/out_tready/out_tdata/out_tuser
//         |     |                              | gauss_x[31:0], gauss_y[63:32]; tuser clipped
// cfg     | in  | APB psel/penable/pwrite/...  | sigma 0x0, x mean 0x4, y mean 0x8
//
// One pair accepted per cycle unless a result waits unclaimed at the output.
// Latency is set by the sqrt(R) unit (32 stages) followed by the divider (31).
// Rejected pairs (zero radius, radius above one) are dropped at stage 2.
// rst_n is synchronous: clears valid bits and loads register defaults.
// A stall at the output freezes every stage together; nothing is lost or repeated.
module gaussian_polar_sampler #(
  parameter int UNIFORM_BITS = gps_pkg::UNIFORM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // uniform_a, uniform_b
  // stream out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // gauss_x, gauss_y
  output logic [0:0]  out_tuser,   // clipped
  // APB config
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // stage indexes of the pipeline registers
  localparam int IDX_R   = 2;
  localparam int IDX_L   = IDX_R + gps_pkg::LOG_LAT;
  localparam int IDX_T   = IDX_L + 2;
  localparam int IDX_G   = IDX_T + gps_pkg::SQG_IW / 2;
  localparam int IDX_SG  = IDX_G + 2;
  localparam int IDX_S   = IDX_R + gps_pkg::SQS_IW / 2;
  localparam int IDX_Q   = IDX_S + gps_pkg::QW;
  localparam int IDX_V   = IDX_Q + 2;
  localparam int IDX_O   = IDX_Q + 3;
  localparam int NST     = IDX_O + 1;
  localparam int SG_DLY  = IDX_Q - IDX_SG;
  localparam int MAG_DLY = IDX_S - IDX_R;
  localparam int SGN_DLY = IDX_V - IDX_R;

  // ---------------- configuration ----------------
  logic [23:0] sigma_r;
  logic [31:0] xmean_r;
  logic [31:0] ymean_r;
  logic [1:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= gps_pkg::SIGMA_RST;
      xmean_r <= '0;
      ymean_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        gps_pkg::REG_SIGMA:  sigma_r <= cfg_pwdata[23:0];
        gps_pkg::REG_X_MEAN: xmean_r <= cfg_pwdata;
        gps_pkg::REG_Y_MEAN: ymean_r <= cfg_pwdata;
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      gps_pkg::REG_SIGMA:  cfg_prdata = {8'd0, sigma_r};
      gps_pkg::REG_X_MEAN: cfg_prdata = xmean_r;
      gps_pkg::REG_Y_MEAN: cfg_prdata = ymean_r;
      default:             cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  // all stages move together; they hold only while a result waits unclaimed
  logic           en;
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic           reject;

  assign en        = !vld_r[IDX_O] || out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[NST-2:0], in_tvalid};
    vld_nxt[IDX_R] = vld_r[IDX_R-1] && !reject;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------- stage 0: map to Q1.31, sign and magnitude ----------------
  logic [31:0] ua, ub;

  if (UNIFORM_BITS >= 32) begin : g_align_r
    assign ua = in_tdata[31:0]  >> (UNIFORM_BITS - 32);
    assign ub = in_tdata[63:32] >> (UNIFORM_BITS - 32);
  end else begin : g_align_l
    assign ua = in_tdata[31:0]  << (32 - UNIFORM_BITS);
    assign ub = in_tdata[63:32] << (32 - UNIFORM_BITS);
  end

  logic [31:0] ax0_r, ay0_r;
  logic        nx0_r, ny0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      nx0_r <= !ua[31];
      ny0_r <= !ub[31];
      ax0_r <= ua[31] ? {1'b0, ua[30:0]} : 32'h8000_0000 - ua;
      ay0_r <= ub[31] ? {1'b0, ub[30:0]} : 32'h8000_0000 - ub;
    end
  end

  // ---------------- stage 1: squares ----------------
  logic [63:0] sqx_r, sqy_r;
  logic [31:0] ax1_r, ay1_r;
  logic        nx1_r, ny1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= ax0_r * ax0_r;
      sqy_r <= ay0_r * ay0_r;
      ax1_r <= ax0_r;
      ay1_r <= ay0_r;
      nx1_r <= nx0_r;
      ny1_r <= ny0_r;
    end
  end

  // ---------------- stage 2: radius and rejection ----------------
  logic [63:0] rsum;
  logic [63:0] r_r;
  logic [31:0] ax2_r, ay2_r;
  logic        nx2_r, ny2_r;

  assign rsum   = sqx_r + sqy_r;
  assign reject = (rsum == 64'd0) || (rsum > gps_pkg::ONE_Q62);

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= rsum;
      ax2_r <= ax1_r;
      ay2_r <= ay1_r;
      nx2_r <= nx1_r;
      ny2_r <= ny1_r;
    end
  end

  // ---------------- radial factor: -2 ln r, sqrt, times sigma ----------------
  logic [gps_pkg::L_W-1:0] l_w;
  logic [60:0]             tp_r;
  logic [30:0]             t_r;
  logic [27:0]             g_w;
  logic [51:0]             sgp_r;
  logic [27:0]             sg_r;
  logic [27:0]             sg_d;

  gps_log2 u_log (
    .clk (clk),
    .en  (en),
    .r   (r_r),
    .l   (l_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      tp_r <= l_w * gps_pkg::TWO_LN2_Q30;
      t_r  <= 31'((tp_r + 61'h2000_0000) >> 30);
    end
  end

  gps_isqrt #(.IW(gps_pkg::SQG_IW)) u_sqrt_g (
    .clk  (clk),
    .en   (en),
    .rad  ({1'b0, t_r, 24'd0}),
    .root (g_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sgp_r <= sigma_r * g_w;
      sg_r  <= 28'((sgp_r + 52'h80_0000) >> 24);
    end
  end

  gps_delay #(.W(28), .N(SG_DLY)) u_dly_sg (
    .clk  (clk),
    .en   (en),
    .din  (sg_r),
    .dout (sg_d)
  );

  // ---------------- direction: x / sqrt(R), y / sqrt(R) ----------------
  logic [31:0]             s_w;
  logic [31:0]             axs, ays;
  logic [gps_pkg::QW-1:0]  qx_w, qy_w;
  logic                    nxv, nyv;

  gps_isqrt #(.IW(gps_pkg::SQS_IW)) u_sqrt_s (
    .clk  (clk),
    .en   (en),
    .rad  (r_r),
    .root (s_w)
  );

  gps_delay #(.W(64), .N(MAG_DLY)) u_dly_mag (
    .clk  (clk),
    .en   (en),
    .din  ({ay2_r, ax2_r}),
    .dout ({ays, axs})
  );

  gps_delay #(.W(2), .N(SGN_DLY)) u_dly_sgn (
    .clk  (clk),
    .en   (en),
    .din  ({ny2_r, nx2_r}),
    .dout ({nyv, nxv})
  );

  gps_div u_div_x (
    .clk (clk),
    .en  (en),
    .mag (axs),
    .den (s_w),
    .quo (qx_w)
  );

  gps_div u_div_y (
    .clk (clk),
    .en  (en),
    .mag (ays),
    .den (s_w),
    .quo (qy_w)
  );

  // ---------------- scale, round ----------------
  logic [58:0] px_r, py_r;
  logic [27:0] vx_r, vy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= sg_d * qx_w;
      py_r <= sg_d * qy_w;
      vx_r <= 28'((px_r + 59'h2000_0000) >> 30);
      vy_r <= 28'((py_r + 59'h2000_0000) >> 30);
    end
  end

  // ---------------- add mean, saturate, output register ----------------
  logic [32:0] smx, smy, sumx, sumy;
  logic [31:0] gx, gy;
  logic        cx, cy;
  logic [31:0] gx_r, gy_r;
  logic        clip_r;

  assign smx  = nxv ? 33'd0 - {5'd0, vx_r} : {5'd0, vx_r};
  assign smy  = nyv ? 33'd0 - {5'd0, vy_r} : {5'd0, vy_r};
  assign sumx = {xmean_r[31], xmean_r} + smx;
  assign sumy = {ymean_r[31], ymean_r} + smy;
  assign cx   = sumx[32] != sumx[31];
  assign cy   = sumy[32] != sumy[31];
  assign gx   = cx ? (sumx[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sumx[31:0];
  assign gy   = cy ? (sumy[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sumy[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r   <= gx;
      gy_r   <= gy;
      clip_r <= cx || cy;
    end
  end

  assign out_tvalid = vld_r[IDX_O];
  assign out_tdata  = {gy_r, gx_r};
  assign out_tuser  = clip_r;

  // ---------------- checks ----------------
  a_radius_ok: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[IDX_R] |-> (r_r != 64'd0 && r_r <= gps_pkg::ONE_Q62))
    else $error("accepted pair outside unit disc");

  a_log_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[IDX_L] |-> (l_w <= gps_pkg::L_MAX))
    else $error("-log2 result above 62");

  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[IDX_Q] |-> (qx_w <= gps_pkg::Q_ONE && qy_w <= gps_pkg::Q_ONE))
    else $error("direction cosine above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved during stall");

endmodule
